// ===== rtl/core/mne_pkg.sv =====
`default_nettype none
package mne_pkg;

   localparam int TRACK_COUNT_DEF = 16;
   localparam int MAX_BYTES       = 14;
   localparam int CNT_W           = 4;
   localparam int REQ_W           = 88;
   localparam int RSP_W           = 8;

   localparam logic [31:0] VLQ_CAP    = 32'h0FFF_FFFF;
   localparam logic [31:0] VLQ_LIM_1  = 32'h0000_0080;
   localparam logic [31:0] VLQ_LIM_2  = 32'h0000_4000;
   localparam logic [31:0] VLQ_LIM_3  = 32'h0020_0000;
   localparam logic [3:0]  STATUS_ON  = 4'h9;
   localparam logic [3:0]  STATUS_OFF = 4'h8;

   typedef logic [7:0] byte_type;

   // later - earlier, floored at zero and capped to the 28-bit VLQ range
   function automatic logic [27:0] clamp_delta(input logic [31:0] later,
                                               input logic [31:0] earlier);
      logic [31:0] d;
      d = later - earlier;
      if (later < earlier) begin
         clamp_delta = '0;
      end else if (d > VLQ_CAP) begin
         clamp_delta = VLQ_CAP[27:0];
      end else begin
         clamp_delta = d[27:0];
      end
   endfunction

   function automatic logic [2:0] vlq_len(input logic [27:0] d);
      logic [31:0] dx;
      dx = {4'h0, d};
      if (dx < VLQ_LIM_1) begin
         vlq_len = 3'd1;
      end else if (dx < VLQ_LIM_2) begin
         vlq_len = 3'd2;
      end else if (dx < VLQ_LIM_3) begin
         vlq_len = 3'd3;
      end else begin
         vlq_len = 3'd4;
      end
   endfunction

   // byte k of one event: n VLQ bytes, status, note, velocity; zero past the end
   function automatic byte_type event_byte(input logic [27:0] d,
                                           input logic [2:0]  n,
                                           input logic [3:0]  k,
                                           input logic [3:0]  status_hi,
                                           input logic [3:0]  chan,
                                           input logic [6:0]  note,
                                           input logic [6:0]  velo);
      logic [3:0] nx;
      logic [3:0] g;
      logic [6:0] grp;
      nx  = {1'b0, n};
      g   = nx - 4'd1 - k;
      grp = '0;
      case (g[1:0])
         2'd0:    grp = d[6:0];
         2'd1:    grp = d[13:7];
         2'd2:    grp = d[20:14];
         2'd3:    grp = d[27:21];
         default: grp = '0;
      endcase
      if (k < nx) begin
         event_byte = {(k != nx - 4'd1), grp};
      end else if (k == nx) begin
         event_byte = {status_hi, chan};
      end else if (k == nx + 4'd1) begin
         event_byte = {1'b0, note};
      end else if (k == nx + 4'd2) begin
         event_byte = {1'b0, velo};
      end else begin
         event_byte = '0;
      end
   endfunction

endpackage
`default_nettype wire

// ===== rtl/core/midi_note_event_encoder_core.sv =====
`default_nettype none
// Channel  Dir  Group         Payload
// req      in   req_t*        one note: track, start/end tick, chan, note, velocity
// rsp      out  rsp_t*        one encoded track byte per transfer, tlast on final byte
//
// A note is held in an input register, then expanded into a 14-byte shift buffer;
// the buffer drains one byte per cycle on rsp while rsp_tready is high.
// Each note gives 8 to 14 output bytes (two events of 4 to 7 bytes each).
// The next note is taken into the input register while the buffer still drains,
// and loads the buffer in the cycle its last byte transfers.
// A note on a track at or above TRACK_COUNT is consumed and gives no bytes.
// Synchronous reset clears all valid flags and every track time to zero.
module midi_note_event_encoder_core
   import mne_pkg::*;
#(
   parameter int TRACK_COUNT = TRACK_COUNT_DEF
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              req_tvalid,
   output logic             req_tready,
   // [3:0] track, [35:4] start_tick, [67:36] end_tick, [71:68] chan,
   // [78:72] note_num, [85:79] velo, [87:86] zero
   input  wire [REQ_W-1:0]  req_tdata,
   output logic             rsp_tvalid,
   input  wire              rsp_tready,
   // [7:0] out_byte
   output logic [RSP_W-1:0] rsp_tdata,
   output logic             rsp_tlast   // last_byte
);

   localparam int TW = (TRACK_COUNT > 1) ? $clog2(TRACK_COUNT) : 1;
   localparam int XW = ((TW > 4) ? TW : 4) + 1;

   // input register
   logic        a_valid_ff, a_valid_in;
   logic [3:0]  a_track_ff;
   logic [31:0] a_start_ff, a_end_ff;
   logic [3:0]  a_chan_ff;
   logic [6:0]  a_note_ff, a_velo_ff;

   // output shift buffer
   byte_type             buf_ff [MAX_BYTES];
   byte_type             buf_in [MAX_BYTES];
   logic [CNT_W-1:0]     cnt_ff, cnt_in;

   logic [31:0] track_time_ff [TRACK_COUNT];

   logic          req_xfer, rsp_xfer, ld, trk_ok;
   logic [XW-1:0] trk_x;
   logic [TW-1:0] trk_idx;
   logic [27:0]   d_on, d_off;
   logic [2:0]    n_on, n_off;
   logic [3:0]    len_on, len_tot;
   byte_type      new_buf [MAX_BYTES];

   assign req_xfer = req_tvalid && req_tready;
   assign rsp_xfer = rsp_tvalid && rsp_tready;
   // buffer takes the held note when empty or when its final byte goes out now
   assign ld         = a_valid_ff && ((cnt_ff == '0) || ((cnt_ff == CNT_W'(1)) && rsp_tready));
   assign req_tready = !a_valid_ff || ld;

   assign rsp_tvalid = (cnt_ff != '0);
   assign rsp_tlast  = (cnt_ff == CNT_W'(1));
   assign rsp_tdata  = buf_ff[0];

   assign trk_x   = XW'(a_track_ff);
   assign trk_ok  = trk_x < XW'(TRACK_COUNT);
   assign trk_idx = trk_x[TW-1:0];

   always_comb begin
      d_on    = clamp_delta(a_start_ff, track_time_ff[trk_idx]);
      d_off   = clamp_delta(a_end_ff, a_start_ff);
      n_on    = vlq_len(d_on);
      n_off   = vlq_len(d_off);
      len_on  = {1'b0, n_on} + 4'd3;
      len_tot = len_on + {1'b0, n_off} + 4'd3;
      for (int i = 0; i < MAX_BYTES; i++) begin
         if (4'(i) < len_on) begin
            new_buf[i] = event_byte(d_on, n_on, 4'(i), STATUS_ON, a_chan_ff,
                                    a_note_ff, a_velo_ff);
         end else begin
            new_buf[i] = event_byte(d_off, n_off, 4'(i) - len_on, STATUS_OFF,
                                    a_chan_ff, a_note_ff, a_velo_ff);
         end
      end
   end

   always_comb begin
      a_valid_in = a_valid_ff;
      if (req_xfer) begin
         a_valid_in = 1'b1;
      end else if (ld) begin
         a_valid_in = 1'b0;
      end

      cnt_in = cnt_ff;
      for (int i = 0; i < MAX_BYTES; i++) begin
         buf_in[i] = buf_ff[i];
      end
      if (rsp_xfer) begin
         cnt_in = cnt_ff - CNT_W'(1);
         for (int i = 0; i < MAX_BYTES - 1; i++) begin
            buf_in[i] = buf_ff[i + 1];
         end
         buf_in[MAX_BYTES-1] = '0;
      end
      if (ld && trk_ok) begin
         cnt_in = len_tot;
         for (int i = 0; i < MAX_BYTES; i++) begin
            buf_in[i] = new_buf[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         cnt_ff     <= '0;
         for (int t = 0; t < TRACK_COUNT; t++) begin
            track_time_ff[t] <= '0;
         end
      end else begin
         a_valid_ff <= a_valid_in;
         cnt_ff     <= cnt_in;
         if (ld && trk_ok) begin
            track_time_ff[trk_idx] <= a_end_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         a_track_ff <= req_tdata[3:0];
         a_start_ff <= req_tdata[35:4];
         a_end_ff   <= req_tdata[67:36];
         a_chan_ff  <= req_tdata[71:68];
         a_note_ff  <= req_tdata[78:72];
         a_velo_ff  <= req_tdata[85:79];
      end
      for (int i = 0; i < MAX_BYTES; i++) begin
         buf_ff[i] <= buf_in[i];
      end
   end

   a_cnt_range: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_W'(MAX_BYTES))
      else $error("byte count out of range");

   a_load_len: assert property (@(posedge clock) disable iff (reset)
      (ld && trk_ok) |=> (cnt_ff >= CNT_W'(8)) && (cnt_ff <= CNT_W'(MAX_BYTES)))
      else $error("loaded note length outside 8..14");

   a_load_only_free: assert property (@(posedge clock) disable iff (reset)
      ld |-> (cnt_ff == '0) || (rsp_xfer && rsp_tlast))
      else $error("buffer loaded while bytes pending");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=> rsp_tvalid && $stable(rsp_tdata)
                                      && $stable(rsp_tlast))
      else $error("rsp changed while stalled");

   a_req_hold: assert property (@(posedge clock) disable iff (reset)
      (a_valid_ff && !ld) |=> a_valid_ff && $stable(a_start_ff) && $stable(a_end_ff)
                              && $stable(a_track_ff))
      else $error("held note changed before load");

endmodule
`default_nettype wire

// ===== dv/tb.sv =====
module tb;
   import mne_pkg::*;

   localparam int CYCLE_LIMIT  = 200000;  // far above the slowest legal run
   localparam int HOLD_CYCLES  = 400;     // long rsp back-pressure stretch
   localparam int RANDOM_NOTES = 130;
   localparam int DRAIN_CYCLES = 30;      // quiet time after the last expected byte

   // one expected rsp transfer
   typedef struct packed {
      logic [7:0] data;
      logic       last;
   } track_byte_type;

   // Tracks per-track running time and the byte stream each accepted note must produce.
   class midi_byte_tracker;
      logic [31:0]    last_tick [TRACK_COUNT_DEF];
      track_byte_type pending_bytes [$];
      int             mismatches;

      function new();
         foreach (last_tick[i]) last_tick[i] = '0;
         mismatches = 0;
      endfunction

      // later - earlier, zero when negative, capped to the 28-bit VLQ range
      function logic [31:0] floor_cap(logic [31:0] later, logic [31:0] earlier);
         if (later < earlier) return '0;
         if (later - earlier > VLQ_CAP) return VLQ_CAP;
         return later - earlier;
      endfunction

      // VLQ delta (big-endian 7-bit groups, continuation bit on all but the last),
      // then status, note, velocity
      function void push_event(logic [31:0] delta, logic [3:0] status_hi,
                               logic [3:0] chan, logic [6:0] note, logic [6:0] velo);
         int             groups;
         logic [31:0]    shifted;
         track_byte_type b;
         if (delta < VLQ_LIM_1) groups = 1;
         else if (delta < VLQ_LIM_2) groups = 2;
         else if (delta < VLQ_LIM_3) groups = 3;
         else groups = 4;
         b.last = 1'b0;
         for (int k = groups - 1; k >= 0; k--) begin
            shifted = delta >> (7 * k);
            b.data  = {(k != 0), shifted[6:0]};
            pending_bytes.push_back(b);
         end
         b.data = {status_hi, chan};
         pending_bytes.push_back(b);
         b.data = {1'b0, note};
         pending_bytes.push_back(b);
         b.data = {1'b0, velo};
         pending_bytes.push_back(b);
      endfunction

      // called on every accepted req transfer
      function void take_note(logic [3:0] track, logic [31:0] start_tick,
                              logic [31:0] stop_tick, logic [3:0] chan,
                              logic [6:0] note, logic [6:0] velo);
         logic [31:0] on_delta;
         logic [31:0] off_delta;
         if (track >= TRACK_COUNT_DEF) return;   // dropped by the block, no bytes
         on_delta  = floor_cap(start_tick, last_tick[track]);
         off_delta = floor_cap(stop_tick, start_tick);
         push_event(on_delta, STATUS_ON, chan, note, velo);
         push_event(off_delta, STATUS_OFF, chan, note, velo);
         pending_bytes[pending_bytes.size() - 1].last = 1'b1;
         // track time follows end tick even when it went backwards
         last_tick[track] = stop_tick;
      endfunction

      // called on every accepted rsp transfer
      function void check_byte(logic [7:0] data, logic last);
         track_byte_type want;
         if (pending_bytes.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected byte %02h last %0b with nothing pending", data, last);
            return;
         end
         want = pending_bytes.pop_front();
         if (want.data !== data || want.last !== last) begin
            mismatches++;
            if (mismatches <= 10)
               $display("byte mismatch: expected %02h last %0b, got %02h last %0b",
                        want.data, want.last, data, last);
         end
      endfunction

      function int outstanding();
         return pending_bytes.size();
      endfunction
   endclass

   logic             clock;
   logic             reset      = 1'b1;
   logic             req_tvalid = 1'b0;
   logic             req_tready;
   logic [REQ_W-1:0] req_tdata  = '0;
   logic             rsp_tvalid;
   logic             rsp_tready = 1'b0;
   logic [RSP_W-1:0] rsp_tdata;
   logic             rsp_tlast;

   midi_byte_tracker scoreboard;
   logic [31:0]      plan_tick [TRACK_COUNT_DEF];  // track times as the stimulus sees them
   int               burst_left = 0;
   bit               hold_req   = 1'b0;            // main asks receiver for a long stall

   midi_note_event_encoder_core u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Sender pacing: bursts of back-to-back transfers, then a gap with tvalid low.
   // Long bursts give stretches with no idling at all.
   task automatic pace_sender();
      int gap;
      if (burst_left > 0) begin
         burst_left--;
         return;
      end
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(15, 30) : $urandom_range(0, 6);
      gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 5);
      req_tvalid <= 1'b0;
      repeat (gap) @(posedge clock);
   endtask

   // Offer one note and hold it until the transfer; tvalid stays high into the next
   // note unless pacing lowers it.
   task automatic send_note(input logic [3:0] track, input logic [31:0] start_tick,
                            input logic [31:0] stop_tick, input logic [3:0] chan,
                            input logic [6:0] note, input logic [6:0] velo);
      req_tdata  <= {2'b00, velo, note, chan, stop_tick, start_tick, track};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      scoreboard.take_note(track, start_tick, stop_tick, chan, note, velo);
      plan_tick[track] = stop_tick;
      pace_sender();
   endtask

   // Delta spread over every VLQ length, the length boundaries and the cap.
   function automatic logic [31:0] pick_delta();
      case ($urandom_range(0, 5))
         0: return $urandom_range(0, 32'h7F);
         1: return $urandom_range(32'h80, 32'h3FFF);
         2: return $urandom_range(32'h4000, 32'h1F_FFFF);
         3: return $urandom_range(32'h20_0000, 32'h0FFF_FFFF);
         4: begin
            case ($urandom_range(0, 7))
               0: return 32'h7F;
               1: return 32'h80;
               2: return 32'h3FFF;
               3: return 32'h4000;
               4: return 32'h1F_FFFF;
               5: return 32'h20_0000;
               6: return 32'h0FFF_FFFF;
               default: return 32'h1000_0000;
            endcase
         end
         default: return $urandom();
      endcase
   endfunction

   // Mostly notes that move forward from the track's time, with some that start
   // before it, end before they start, or are fully random.
   task automatic send_random_note();
      logic [3:0]  trk;
      logic [31:0] s_tick;
      logic [31:0] e_tick;
      int          shape;
      trk   = 4'($urandom_range(0, TRACK_COUNT_DEF - 1));
      shape = $urandom_range(0, 9);
      if (shape == 0) begin
         s_tick = $urandom();
         e_tick = $urandom();
      end else if (shape == 1) begin
         s_tick = plan_tick[trk] - $urandom_range(1, 5000);
         e_tick = s_tick + pick_delta();
      end else begin
         s_tick = plan_tick[trk] + pick_delta();
         e_tick = (shape == 2) ? s_tick - $urandom_range(1, 300) : s_tick + pick_delta();
      end
      send_note(trk, s_tick, e_tick, 4'($urandom_range(0, 15)),
                7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
   endtask

   // Receiver: checks each rsp transfer, then picks tready from one of four
   // patterns, chosen anew at random. A hold request stalls it for HOLD_CYCLES so
   // the note register and byte buffer fill and req_tready drops.
   initial begin : receiver
      int mode;
      int mode_left;
      int phase;
      mode      = 0;
      mode_left = 0;
      phase     = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_tvalid && rsp_tready)
            scoreboard.check_byte(rsp_tdata, rsp_tlast);
         if (hold_req) begin
            hold_req = 1'b0;
            rsp_tready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            if (mode_left == 0) begin
               mode      = $urandom_range(0, 3);
               mode_left = $urandom_range(16, 80);
            end
            mode_left--;
            phase++;
            case (mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(0, 1));
               2:       rsp_tready <= (phase % 3 == 0);
               default: rsp_tready <= ($urandom_range(0, 3) != 0);
            endcase
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < CYCLE_LIMIT) begin
         @(posedge clock);
         cycles++;
      end
      $display("FAIL midi_note_event_encoder_core");
      $finish;
   end

   initial begin : stimulus
      scoreboard = new();
      foreach (plan_tick[i]) plan_tick[i] = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // zero deltas, all-zero fields
      send_note(4'd0, 32'h0, 32'h0, 4'h0, 7'h00, 7'h00);
      // one-byte max on, two-byte min off
      send_note(4'd0, 32'h7F, 32'hFF, 4'h3, 7'h3C, 7'h40);
      // two-byte max, three-byte min; all-ones chan/note/velo
      send_note(4'd1, 32'h3FFF, 32'h7FFF, 4'hF, 7'h7F, 7'h7F);
      // three-byte max on, four-byte min off
      send_note(4'd2, 32'h1F_FFFF, 32'h3F_FFFF, 4'h1, 7'h01, 7'h01);
      // on delta exactly at cap, off delta just over it
      send_note(4'd3, 32'h0FFF_FFFF, 32'h1FFF_FFFF, 4'h8, 7'h40, 7'h20);
      // start before track time and end before start: both deltas clamp to zero,
      // track time still moves back to end tick
      send_note(4'd3, 32'h5, 32'h3, 4'h2, 7'h11, 7'h22);
      send_note(4'd3, 32'h4, 32'hFFFF_FFFF, 4'h4, 7'h33, 7'h44);
      // top of the tick range, top track
      send_note(4'd15, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'hA, 7'h55, 7'h2A);
      send_note(4'd15, 32'h0, 32'h0, 4'h5, 7'h2A, 7'h55);
      // off delta exactly at cap
      send_note(4'd4, 32'h0FFF_FFFF, 32'h1FFF_FFFE, 4'h6, 7'h10, 7'h70);
      // on delta over cap
      send_note(4'd5, 32'h1000_0000, 32'h1000_3FFF, 4'h7, 7'h0F, 7'h7E);
      send_note(4'd6, 32'h80, 32'hFF, 4'h9, 7'h6E, 7'h0C);
      send_note(4'd7, 32'h4000, 32'h20_3FFF, 4'hB, 7'h5A, 7'h19);
      send_note(4'd8, 32'h20_0000, 32'h101F_FFFE, 4'hC, 7'h24, 7'h5B);
      send_note(4'd9, 32'hAAAA_AAAA, 32'h5555_5555, 4'hD, 7'h2A, 7'h55);
      send_note(4'd9, 32'h5555_5555, 32'h5555_5556, 4'hE, 7'h55, 7'h2A);

      for (int i = 0; i < RANDOM_NOTES; i++) begin
         if (i == 40) hold_req = 1'b1;
         send_random_note();
      end
      if (req_tvalid) req_tvalid <= 1'b0;

      while (scoreboard.outstanding() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (scoreboard.mismatches == 0 && scoreboard.outstanding() == 0) begin
         $display("PASS midi_note_event_encoder_core");
      end else begin
         $display("FAIL midi_note_event_encoder_core");
      end
      $finish;
   end

endmodule
